### src/tlrl_pkg.sv
package tlrl_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LOCK  = 2'd1,
    FUNC_OPEN  = 2'd2,
    FUNC_CLOSE = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_LOCKED = 2'd1,
    ST_BUSY   = 2'd2,
    ST_PASSED = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PULSE_LENGTH  = 3'd0,
    REG_DARK_ABOVE    = 3'd1,
    REG_SLOW_ABOVE    = 3'd2,
    REG_SLOW_INTERVAL = 3'd3,
    REG_FAST_INTERVAL = 3'd4,
    REG_BRIGHT_STEP   = 3'd5
  } cfg_reg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [15:0] PULSE_LENGTH_RST  = 16'd2000;
  localparam logic [15:0] DARK_ABOVE_RST    = 16'd1800;
  localparam logic [15:0] SLOW_ABOVE_RST    = 16'd600;
  localparam logic [15:0] SLOW_INTERVAL_RST = 16'd40;
  localparam logic [15:0] FAST_INTERVAL_RST = 16'd10;
  localparam logic [7:0]  BRIGHT_STEP_RST   = 8'd2;

  localparam logic [7:0]  LED_FULL = 8'hFF;
  localparam logic [7:0]  LED_DARK = 8'h00;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [15:0] pulse_length_ms;
    logic [15:0] dark_above_sec;
    logic [15:0] slow_above_sec;
    logic [15:0] slow_interval_ms;
    logic [15:0] fast_interval_ms;
    logic [7:0]  brightness_step;
  } cfg_t;

  typedef struct packed {
    logic        relay_on;
    logic [7:0]  led_level;
    logic        lock_held;
    logic        pulse_running;
    logic [31:0] seconds_left;
    status_t     status;
  } res_t;

endpackage

### src/tlrl_item_if.sv
interface tlrl_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_sec;
  logic [31:0] unlock_sec;

  modport source (output valid, output func, output now_sec, output unlock_sec, input ready);
  modport sink   (input valid, input func, input now_sec, input unlock_sec, output ready);
endinterface

### src/tlrl_result_if.sv
interface tlrl_result_if;
  logic        valid;
  logic        ready;
  logic        relay_on;
  logic [7:0]  led_level;
  logic        lock_held;
  logic        pulse_running;
  logic [31:0] seconds_left;
  logic [1:0]  status;

  modport source (output valid, output relay_on, output led_level, output lock_held,
                  output pulse_running, output seconds_left, output status, input ready);
  modport sink   (input valid, input relay_on, input led_level, input lock_held,
                  input pulse_running, input seconds_left, input status, output ready);
endinterface

### src/time_lock_relay_led_controller_top.sv
// Channel  | Dir | Payload                                                    | Handshake
// item     | in  | func, now_sec, unlock_sec                                  | valid/ready
// result   | out | relay_on, led_level, lock_held, pulse_running,             | valid/ready
//          |     | seconds_left, status                                       |
// cfg      | in  | cfg_index, cfg_data                                        | cfg_write
//
// One request per cycle sustained while result.ready holds; a taken request passes
// through the input register, one pass of compare/count logic and the result register.
// Synchronous active-high reset clears state and both stages; no clearing pass.
// A stalled result holds in the result register while the request behind it waits
// in the input register; item.ready drops only when both stages are full.
module time_lock_relay_led_controller_top
  import tlrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  tlrl_item_if.sink              item,
  tlrl_result_if.source          result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  res_t        res;
  logic        in_valid;
  logic [1:0]  in_func;
  logic [31:0] in_now;
  logic [31:0] in_unlock;
  logic        out_valid;
  res_t        out_res;
  logic        advance;
  logic        take;

  tlrl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlrl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .go         (advance),
    .func       (in_func),
    .now_sec    (in_now),
    .unlock_sec (in_unlock),
    .res        (res)
  );

  // Stage handshakes
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign take       = item.valid && item.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= take || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_func   <= item.func;
      in_now    <= item.now_sec;
      in_unlock <= item.unlock_sec;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.relay_on      = out_res.relay_on;
  assign result.led_level     = out_res.led_level;
  assign result.lock_held     = out_res.lock_held;
  assign result.pulse_running = out_res.pulse_running;
  assign result.seconds_left  = out_res.seconds_left;
  assign result.status        = out_res.status;

endmodule

### src/tlrl_cfg.sv
module tlrl_cfg
  import tlrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_length_ms  <= PULSE_LENGTH_RST;
      cfg.dark_above_sec   <= DARK_ABOVE_RST;
      cfg.slow_above_sec   <= SLOW_ABOVE_RST;
      cfg.slow_interval_ms <= SLOW_INTERVAL_RST;
      cfg.fast_interval_ms <= FAST_INTERVAL_RST;
      cfg.brightness_step  <= BRIGHT_STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE_LENGTH:  cfg.pulse_length_ms  <= cfg_data;
        REG_DARK_ABOVE:    cfg.dark_above_sec   <= cfg_data;
        REG_SLOW_ABOVE:    cfg.slow_above_sec   <= cfg_data;
        REG_SLOW_INTERVAL: cfg.slow_interval_ms <= cfg_data;
        REG_FAST_INTERVAL: cfg.fast_interval_ms <= cfg_data;
        REG_BRIGHT_STEP:   cfg.brightness_step  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### src/tlrl_core.sv
module tlrl_core
  import tlrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        go,
  input  logic [1:0]  func,
  input  logic [31:0] now_sec,
  input  logic [31:0] unlock_sec,
  output res_t        res
);

  // Controller state
  logic        lock_active, lock_active_next;
  logic [31:0] unlock_time, unlock_time_next;
  logic        pulse_flag, pulse_flag_next;
  logic [15:0] pulse_elapsed, pulse_elapsed_next;
  logic        relay_level, relay_level_next;
  logic [7:0]  breath_level, breath_level_next;
  logic        breath_rising, breath_rising_next;
  logic [15:0] step_timer, step_timer_next;
  logic [7:0]  led_out, led_out_next;

  logic [15:0]        pe_inc;
  logic [15:0]        st_inc;
  logic               lock_expired;
  logic [31:0]        left_cur;
  logic [15:0]        interval;
  logic signed [9:0]  bsum;
  logic [7:0]         bv;
  logic               br;
  logic               ahead;
  status_t            status;

  // Saturating counters and lock distance
  assign pe_inc       = (pulse_elapsed != CNT_MAX) ? pulse_elapsed + 16'd1 : pulse_elapsed;
  assign st_inc       = (step_timer != CNT_MAX) ? step_timer + 16'd1 : step_timer;
  assign lock_expired = (unlock_time <= now_sec);
  assign left_cur     = unlock_time - now_sec;
  assign interval     = (left_cur > {16'd0, cfg.slow_above_sec}) ? cfg.slow_interval_ms
                                                                  : cfg.fast_interval_ms;

  // Triangle ramp step, clamped at both ends
  always_comb begin
    bsum = breath_rising ? signed'({2'b00, breath_level} + {2'b00, cfg.brightness_step})
                         : signed'({2'b00, breath_level} - {2'b00, cfg.brightness_step});
    if (bsum >= 10'sd255) begin
      bv = LED_FULL;
      br = 1'b0;
    end else if (bsum <= 10'sd0) begin
      bv = LED_DARK;
      br = 1'b1;
    end else begin
      bv = bsum[7:0];
      br = breath_rising;
    end
  end

  // Per-item state update
  always_comb begin
    lock_active_next   = lock_active;
    unlock_time_next   = unlock_time;
    pulse_flag_next    = pulse_flag;
    pulse_elapsed_next = pulse_elapsed;
    relay_level_next   = relay_level;
    breath_level_next  = breath_level;
    breath_rising_next = breath_rising;
    step_timer_next    = step_timer;
    led_out_next       = led_out;
    status             = ST_DONE;
    unique case (func_t'(func))
      FUNC_TICK: begin
        pulse_elapsed_next = pe_inc;
        step_timer_next    = st_inc;
        if (pulse_flag && pe_inc >= cfg.pulse_length_ms) begin
          relay_level_next = 1'b0;
          pulse_flag_next  = 1'b0;
        end
        if (lock_active && lock_expired) begin
          lock_active_next = 1'b0;
        end
        // LED: full during pulse, dark / breathing while locked, full otherwise
        if (pulse_flag_next) begin
          led_out_next = LED_FULL;
        end else if (lock_active_next) begin
          if (left_cur > {16'd0, cfg.dark_above_sec}) begin
            led_out_next = LED_DARK;
          end else if (st_inc >= interval) begin
            step_timer_next    = 16'd0;
            breath_level_next  = bv;
            breath_rising_next = br;
            led_out_next       = bv;
          end
        end else begin
          led_out_next = LED_FULL;
        end
      end
      FUNC_LOCK: begin
        if (unlock_sec <= now_sec) begin
          status = ST_PASSED;
        end else begin
          unlock_time_next = unlock_sec;
          lock_active_next = 1'b1;
        end
      end
      FUNC_OPEN: begin
        if (lock_active && lock_expired) begin
          lock_active_next = 1'b0;
        end
        if (lock_active && !lock_expired) begin
          status = ST_LOCKED;
        end else if (pulse_flag) begin
          status = ST_BUSY;
        end else begin
          relay_level_next   = 1'b1;
          pulse_flag_next    = 1'b1;
          pulse_elapsed_next = 16'd0;
        end
      end
      FUNC_CLOSE: begin
        relay_level_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Result fields after this item
  assign ahead = lock_active_next && (unlock_time_next > now_sec);

  always_comb begin
    res.relay_on      = relay_level_next;
    res.led_level     = led_out_next;
    res.lock_held     = lock_active_next;
    res.pulse_running = pulse_flag_next;
    res.seconds_left  = ahead ? unlock_time_next - now_sec : 32'd0;
    res.status        = status;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_active   <= 1'b0;
      unlock_time   <= 32'd0;
      pulse_flag    <= 1'b0;
      pulse_elapsed <= 16'd0;
      relay_level   <= 1'b0;
      breath_level  <= 8'd0;
      breath_rising <= 1'b1;
      step_timer    <= CNT_MAX;
      led_out       <= 8'd0;
    end else if (go) begin
      lock_active   <= lock_active_next;
      unlock_time   <= unlock_time_next;
      pulse_flag    <= pulse_flag_next;
      pulse_elapsed <= pulse_elapsed_next;
      relay_level   <= relay_level_next;
      breath_level  <= breath_level_next;
      breath_rising <= breath_rising_next;
      step_timer    <= step_timer_next;
      led_out       <= led_out_next;
    end
  end

endmodule
